// ===== rtl/gam_pkg.sv =====
// ----------------------------------------------------------------------------
// gam_pkg
// Shared beat types, fixed constants and rounding helper for the gated
// activation multiply block.
// ----------------------------------------------------------------------------
package gam_pkg;

   // input beat: gate and up elements plus end-of-vector mark
   typedef struct packed {
      logic signed [15:0] gate_value;
      logic signed [15:0] up_value;
      logic               last_in;
   } req_beat_type;

   // result beat
   typedef struct packed {
      logic signed [15:0] gated_result;
      logic               saturated;
      logic               last_out;
   } rsp_beat_type;

   // gelu constants: 2*sqrt(2/pi) in Q16, cubic coefficient in Q20
   localparam logic [16:0] GELU_K1_Q16 = 17'd104581;
   localparam logic [15:0] GELU_C2_Q20 = 16'd46886;

   // sigmoid value width, unsigned Q16 up to 1.0
   localparam int SIG_W = 17;
   // width of the sigmoid argument
   localparam int Z_W   = 34;

   // shift right by sh with rounding to nearest, ties away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned sh);
      logic [63:0] mag;
      logic [63:0] res;
      mag = v[63] ? 64'(-v) : 64'(v);
      res = (sh == 0) ? mag : ((mag + (64'd1 << (sh - 1))) >> sh);
      return v[63] ? -$signed(res) : $signed(res);
   endfunction

endpackage

// ===== rtl/gam_gelu_arg.sv =====
// ----------------------------------------------------------------------------
// gam_gelu_arg
// Six-stage pipeline that forms the sigmoid argument: the gate value itself
// for silu, or 2*c1*(g + c2*g^3) for tanh gelu.
// ----------------------------------------------------------------------------
module gam_gelu_arg #(
   parameter int FRAC_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        mode,
   input  logic                        in_valid,
   input  gam_pkg::req_beat_type       in_beat,
   output logic                        out_valid,
   output gam_pkg::req_beat_type       out_beat,
   output logic signed [gam_pkg::Z_W-1:0] out_z
);
   import gam_pkg::*;

   localparam int STAGES = 6;
   localparam int CUBE_SH = 2 * FRAC_BITS + 20;

   logic [STAGES-1:0]    valid_ff;
   req_beat_type         beat_ff [STAGES];

   logic [30:0]          gg_ff;
   logic [15:0]          ga_ff;
   logic [45:0]          m3_ff;
   logic                 neg_ff [2:4];
   logic [38:0]          plo_ff;
   logic [38:0]          phi_ff;
   logic signed [31:0]   inner_ff;
   logic signed [49:0]   zp_ff;
   logic signed [Z_W-1:0] z_ff;

   logic signed [31:0]   gg_in;
   logic [63:0]          cube_sum;
   logic [63:0]          q_in;
   logic signed [31:0]   inner_in;
   logic signed [63:0]   zr_in;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   // side payload shift line
   always_ff @(posedge clock) begin
      if (adv) begin
         beat_ff[0] <= in_beat;
         for (int i = 1; i < STAGES; i++) begin
            beat_ff[i] <= beat_ff[i-1];
         end
      end
   end

   // square, recombination of the split cube coefficient product, inner sum, rounding
   always_comb begin
      gg_in    = in_beat.gate_value * in_beat.gate_value;
      cube_sum = ({25'd0, phi_ff} << 23) + {25'd0, plo_ff} + (64'd1 << (CUBE_SH - 1));
      q_in     = cube_sum >> CUBE_SH;
      inner_in = neg_ff[4] ? 32'(beat_ff[2].gate_value) - $signed(q_in[31:0])
                           : 32'(beat_ff[2].gate_value) + $signed(q_in[31:0]);
      zr_in    = round_shift(64'(zp_ff), 16);
   end

   // arithmetic stages
   always_ff @(posedge clock) begin
      if (adv) begin
         // square and magnitude
         gg_ff     <= gg_in[30:0];
         ga_ff     <= in_beat.gate_value[15] ? 16'(-in_beat.gate_value)
                                             : 16'(in_beat.gate_value);
         neg_ff[2] <= in_beat.gate_value[15];
         // cube magnitude
         m3_ff     <= 46'({16'd0, gg_ff} * {31'd0, ga_ff});
         neg_ff[3] <= neg_ff[2];
         // cube times coefficient, partial products
         plo_ff    <= 39'(m3_ff[22:0] * GELU_C2_Q20);
         phi_ff    <= 39'(m3_ff[45:23] * GELU_C2_Q20);
         neg_ff[4] <= neg_ff[3];
         // inner sum
         inner_ff  <= inner_in;
         // scale by 2*c1
         zp_ff     <= 50'(inner_ff * $signed({1'b0, GELU_K1_Q16}));
         // round and select the activation
         z_ff      <= mode ? Z_W'(zr_in) : Z_W'(beat_ff[4].gate_value);
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_beat  = beat_ff[STAGES-1];
   assign out_z     = z_ff;

endmodule

// ===== rtl/gam_sigmoid.sv =====
// ----------------------------------------------------------------------------
// gam_sigmoid
// Five-stage sigmoid: clamp, table index, table read, interpolation product,
// rounding. Table covers [-8, 8] in unsigned Q16.
// ----------------------------------------------------------------------------
module gam_sigmoid #(
   parameter int FUNC_TABLE_DEPTH = 256,
   parameter int FRAC_BITS        = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  gam_pkg::req_beat_type          in_beat,
   input  logic signed [gam_pkg::Z_W-1:0] in_z,
   output logic                           out_valid,
   output gam_pkg::req_beat_type          out_beat,
   output logic [gam_pkg::SIG_W-1:0]      out_sig
);
   import gam_pkg::*;

   localparam int STAGES = 5;
   localparam int OFF_W  = FRAC_BITS + 4;
   localparam int IDX_W  = $clog2(FUNC_TABLE_DEPTH + 1);
   localparam int POS_W  = OFF_W + IDX_W;
   localparam int P_W    = SIG_W + 1 + OFF_W + 1;
   localparam logic signed [Z_W-1:0] Lim = Z_W'(8 << FRAC_BITS);

   typedef logic [SIG_W-1:0] tab_type [0:FUNC_TABLE_DEPTH];

   // shift-subtract long division, used only while building the table
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] rem;
      q   = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[63:0], n[k]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid table built at elaboration in exact integer arithmetic
   function automatic tab_type build_tab();
      tab_type     t;
      logic [63:0] pos;
      logic [63:0] mid;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t2;
      logic [63:0] t3;
      logic [63:0] t4;
      logic [63:0] r;
      logic [63:0] one;
      logic [63:0] den;
      logic [63:0] num;
      logic        nonneg;
      one = 64'd1 << 31;
      mid = 64'd1 << 35;
      for (int i = 0; i <= FUNC_TABLE_DEPTH; i++) begin
         pos    = udiv(64'(i) << 36, 64'(FUNC_TABLE_DEPTH));
         nonneg = pos >= mid;
         a      = nonneg ? pos - mid : mid - pos;
         // exp(-a/2): taylor of exp(-a/512), squared eight times
         b  = a >> 9;
         t2 = (b * b) >> 31;
         t3 = (t2 * b) >> 31;
         t4 = (t3 * b) >> 31;
         r  = one - b + (t2 >> 1) - udiv(t3, 64'd6) + udiv(t4, 64'd24);
         for (int k = 0; k < 8; k++) begin
            r = (r * r + (64'd1 << 30)) >> 31;
         end
         den  = one + r;
         num  = nonneg ? one : r;
         t[i] = SIG_W'(udiv((num << 16) + (den >> 1), den));
      end
      return t;
   endfunction

   localparam tab_type SigTab = build_tab();

   logic [STAGES-1:0]       valid_ff;
   req_beat_type            beat_ff [STAGES];
   logic                    lo_sat_ff [STAGES-1];
   logic                    hi_sat_ff [STAGES-1];
   logic [OFF_W-1:0]        off_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [OFF_W-1:0]        fr_ff [2:3];
   logic [SIG_W-1:0]        lo_ff [3:4];
   logic [SIG_W-1:0]        hi_ff;
   logic signed [P_W-1:0]   p_ff;
   logic [SIG_W-1:0]        sig_ff;

   logic signed [Z_W-1:0]   off_in;
   logic [POS_W-1:0]        pos_in;
   logic signed [63:0]      q_in;
   logic [SIG_W-1:0]        sig_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-2:0], in_valid};
      end
   end

   // side payload and clamp flags
   always_ff @(posedge clock) begin
      if (adv) begin
         beat_ff[0]   <= in_beat;
         lo_sat_ff[0] <= in_z <= -Lim;
         hi_sat_ff[0] <= in_z >= Lim;
         for (int i = 1; i < STAGES; i++) begin
            beat_ff[i] <= beat_ff[i-1];
         end
         for (int i = 1; i < STAGES - 1; i++) begin
            lo_sat_ff[i] <= lo_sat_ff[i-1];
            hi_sat_ff[i] <= hi_sat_ff[i-1];
         end
      end
   end

   always_comb begin
      off_in = in_z + Lim;
      pos_in = POS_W'(off_ff) * POS_W'(FUNC_TABLE_DEPTH);
      q_in   = round_shift(64'(p_ff), OFF_W);
      priority if (lo_sat_ff[3]) begin
         sig_in = SigTab[0];
      end else if (hi_sat_ff[3]) begin
         sig_in = SigTab[FUNC_TABLE_DEPTH];
      end else begin
         sig_in = SIG_W'($signed({1'b0, lo_ff[4]}) + q_in);
      end
   end

   // offset, index, table read, slope product, rounding
   always_ff @(posedge clock) begin
      if (adv) begin
         off_ff    <= off_in[OFF_W-1:0];
         idx_ff    <= pos_in[POS_W-1:OFF_W];
         fr_ff[2]  <= pos_in[OFF_W-1:0];
         lo_ff[3]  <= SigTab[idx_ff];
         hi_ff     <= SigTab[idx_ff + IDX_W'(1)];
         fr_ff[3]  <= fr_ff[2];
         p_ff      <= P_W'(($signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff[3]}))
                          * $signed({1'b0, fr_ff[3]}));
         lo_ff[4]  <= lo_ff[3];
         sig_ff    <= sig_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_beat  = beat_ff[STAGES-1];
   assign out_sig   = sig_ff;

endmodule

// ===== rtl/gam_product.sv =====
// ----------------------------------------------------------------------------
// gam_product
// Three-stage output product: gate times sigmoid, times up, then rounding
// and saturation into the result register.
// ----------------------------------------------------------------------------
module gam_product #(
   parameter int FRAC_BITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  gam_pkg::req_beat_type     in_beat,
   input  logic [gam_pkg::SIG_W-1:0] in_sig,
   output logic                      out_valid,
   output gam_pkg::rsp_beat_type     out_beat
);
   import gam_pkg::*;

   logic [2:0]          valid_ff;
   logic signed [15:0]  up_ff;
   logic                last_ff [2];
   logic signed [33:0]  gs_ff;
   logic signed [49:0]  gsu_ff;
   rsp_beat_type        rsp_ff;

   logic signed [63:0]  r_in;
   rsp_beat_type        rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // round and saturate
   always_comb begin
      r_in = round_shift(64'(gsu_ff), 16 + FRAC_BITS);
      rsp_in.last_out = last_ff[1];
      priority if (r_in > 64'sd32767) begin
         rsp_in.gated_result = 16'sh7fff;
         rsp_in.saturated    = 1'b1;
      end else if (r_in < -64'sd32768) begin
         rsp_in.gated_result = 16'sh8000;
         rsp_in.saturated    = 1'b1;
      end else begin
         rsp_in.gated_result = r_in[15:0];
         rsp_in.saturated    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gs_ff      <= 34'(in_beat.gate_value * $signed({1'b0, in_sig}));
         up_ff      <= in_beat.up_value;
         last_ff[0] <= in_beat.last_in;
         gsu_ff     <= 50'(gs_ff * up_ff);
         last_ff[1] <= last_ff[0];
         rsp_ff     <= rsp_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_beat  = rsp_ff;

endmodule

// ===== rtl/gated_activation_multiply.sv =====
// ----------------------------------------------------------------------------
// gated_activation_multiply
// Elementwise act(gate) * up with silu or tanh gelu, saturated to 16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_beat carry gate, up and the last mark; a beat is
//   taken when req_valid is high and req_stall is low.
//   rsp_valid/rsp_stall/rsp_beat return the result, saturation flag and
//   copied last mark, one result beat per request beat, in order.
//   csr_write/csr_data set the activation select (1 = tanh gelu, 0 = silu);
//   write only while the pipeline is empty.
// Pipeline: 6 argument stages, 5 sigmoid stages and 3 product stages lie
//   between request beat and result beat.
// Throughput: one beat per cycle unless rsp_stall holds the pipeline; every
//   stage holds at most one beat and the whole pipeline advances together.
// Reset: clears all valid bits and selects silu; sigmoid table is constant.
// Stall: while a result is shown and rsp_stall is high, the pipeline
//   freezes and req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gated_activation_multiply #(
   parameter int FUNC_TABLE_DEPTH = 256,
   parameter int FRAC_BITS        = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gam_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gam_pkg::rsp_beat_type rsp_beat,
   input  logic                  csr_write,
   input  logic                  csr_data
);
   import gam_pkg::*;

   logic                  mode_ff;
   logic                  adv;
   logic                  arg_valid;
   req_beat_type          arg_beat;
   logic signed [Z_W-1:0] arg_z;
   logic                  sig_valid;
   req_beat_type          sig_beat;
   logic [SIG_W-1:0]      sig_val;

   // activation select register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write) begin
         mode_ff <= csr_data;
      end
   end

   // pipeline advances unless the result register is held
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   gam_gelu_arg #(
      .FRAC_BITS (FRAC_BITS)
   ) u_arg (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .mode      (mode_ff),
      .in_valid  (req_valid),
      .in_beat   (req_beat),
      .out_valid (arg_valid),
      .out_beat  (arg_beat),
      .out_z     (arg_z)
   );

   gam_sigmoid #(
      .FUNC_TABLE_DEPTH (FUNC_TABLE_DEPTH),
      .FRAC_BITS        (FRAC_BITS)
   ) u_sig (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (arg_valid),
      .in_beat   (arg_beat),
      .in_z      (arg_z),
      .out_valid (sig_valid),
      .out_beat  (sig_beat),
      .out_sig   (sig_val)
   );

   gam_product #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prod (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sig_valid),
      .in_beat   (sig_beat),
      .in_sig    (sig_val),
      .out_valid (rsp_valid),
      .out_beat  (rsp_beat)
   );

endmodule
